// File: rtl/bse_pkg.sv
// ============================================================================
// bse_pkg: shared types and constants of the bitmap set engine
// Request codes, item structs and the command and status bundles that join
// the controller to the datapath.
// ============================================================================
package bse_pkg;

  // Word geometry of the bitmap store.
  localparam int WORD_W = 16;
  localparam int IDX_W = 11;
  localparam int WIDX_W = 7;
  localparam int WCNT_W = 8;
  localparam int MAX_SNAP_WORDS = 64;

  // Request codes.
  localparam logic [3:0] REQ_SET        = 4'd0;
  localparam logic [3:0] REQ_CLEAR      = 4'd1;
  localparam logic [3:0] REQ_TEST       = 4'd2;
  localparam logic [3:0] REQ_TEST_SET   = 4'd3;
  localparam logic [3:0] REQ_TEST_CLEAR = 4'd4;
  localparam logic [3:0] REQ_ANY        = 4'd5;
  localparam logic [3:0] REQ_COUNT      = 4'd6;
  localparam logic [3:0] REQ_SCAN       = 4'd7;
  localparam logic [3:0] REQ_CLEAR_ALL  = 4'd8;
  localparam logic [3:0] REQ_FILL_ALL   = 4'd9;
  localparam logic [3:0] REQ_SNAPSHOT   = 4'd10;

  // Configuration port.
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;
  localparam logic CFG_IDX_BITS_IN_USE = 1'b0;
  localparam logic [IDX_W-1:0] BITS_IN_USE_RESET = 11'd1024;

  // One request item.
  typedef struct packed {
    logic [3:0]       req_type;
    logic [IDX_W-1:0] bit_index;
    logic [6:0]       dest_space;
  } req_t;

  // One result item.
  typedef struct packed {
    logic              ok;
    logic              bit_value;
    logic              any_set;
    logic [IDX_W-1:0]  set_count;
    logic [IDX_W-1:0]  found_index;
    logic [WORD_W-1:0] word_data;
    logic              last;
  } rsp_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic accept;    // take the input item, start at its first word
    logic clr_step;  // write one zero word of the reset clearing pass
    logic bit_op;    // single-bit read-modify-write on the current word
    logic proc;      // fold the current word into a walk, or fill it
    logic step;      // advance to the next word
    logic load_res;  // load the output register
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic bad;        // request is rejected
    logic single;     // single-bit request
    logic snap;       // snapshot request
    logic empty;      // no word to visit
    logic last_word;  // current word is the last one in use
    logic hit;        // scan found a set bit in the current word
    logic out_free;   // output register can take an item this cycle
    logic clr_done;   // clearing pass is on its last word
  } stat_t;

endpackage

// File: rtl/bitmap_set_engine.sv
// ============================================================================
// bitmap_set_engine: bitmap with set, clear, test, count, scan and snapshot
// Top level: configuration register, controller and datapath.
// ============================================================================
//
//   channel | ports                           | moves
//   --------+---------------------------------+-------------------------------
//   in      | in_valid, in_stall, in_data     | one request item
//   out     | out_valid, out_stall, out_data  | one result item (several for
//           |                                 | a snapshot)
//   cfg     | cfg_psel ... cfg_pready         | bits_in_use register
//
// A single-bit request reads its word when the item is taken and updates it in
// the cycle after. Any, count, scan, clear-all and fill-all take the item, then
// visit the words in use in turn; a scan starts at the word of its start bit and
// stops at its first hit. The store has one read and one write port and visits a
// word per cycle. A snapshot sends one word per cycle while out_stall is low.
// After reset a clearing pass writes zeros to all ceil(CAPACITY_BITS/16) words
// (64 by default) with in_stall high; configuration writes are taken as ever.
// A new item is taken while a finished result waits in the output register.
module bitmap_set_engine #(
  parameter int CAPACITY_BITS = 1024
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  bse_pkg::req_t                     in_data,
  output logic                              out_valid,
  input  logic                              out_stall,
  output bse_pkg::rsp_t                     out_data,
  input  logic                              cfg_psel,
  input  logic                              cfg_penable,
  input  logic                              cfg_pwrite,
  input  logic [bse_pkg::CFG_ADDR_W-1:0]    cfg_paddr,
  input  logic [bse_pkg::CFG_DATA_W-1:0]    cfg_pwdata,
  output logic [bse_pkg::CFG_DATA_W-1:0]    cfg_prdata,
  output logic                              cfg_pready
);

  logic [bse_pkg::IDX_W-1:0] bits_in_use_r, bits_in_use_nxt;
  logic                      cfg_hit;
  bse_pkg::cmd_t             cmd;
  bse_pkg::stat_t            st;

  // Register decode and read-back.
  assign cfg_pready = 1'b1;
  assign cfg_hit = (cfg_paddr[2] == bse_pkg::CFG_IDX_BITS_IN_USE);
  assign cfg_prdata = cfg_hit ? 32'(bits_in_use_r) : 32'd0;
  assign bits_in_use_nxt = (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready && cfg_hit)
                           ? cfg_pwdata[bse_pkg::IDX_W-1:0] : bits_in_use_r;

  // Configuration register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bits_in_use_r <= bse_pkg::BITS_IN_USE_RESET;
    end else begin
      bits_in_use_r <= bits_in_use_nxt;
    end
  end

  bse_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .st      (st),
    .cmd     (cmd)
  );

  bse_dp #(
    .CAPACITY_BITS(CAPACITY_BITS)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .bits_in_use(bits_in_use_r),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data),
    .cmd        (cmd),
    .st         (st)
  );

endmodule

// File: rtl/bse_ram.sv
// ============================================================================
// bse_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle; a read returns the old data
// when it meets a write to the same address.
// ============================================================================
module bse_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: rtl/bse_ctrl.sv
// ============================================================================
// bse_ctrl: controller of the bitmap set engine
// Sequences the reset clearing pass, the single-bit read-modify-write, the
// word walks and the snapshot output, driven by datapath status.
// ============================================================================
module bse_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_stall,
  input  bse_pkg::stat_t st,
  output bse_pkg::cmd_t  cmd
);

  typedef enum logic [5:0] {
    S_CLR  = 6'b000001,
    S_IDLE = 6'b000010,
    S_DEC  = 6'b000100,
    S_WALK = 6'b001000,
    S_SNAP = 6'b010000,
    S_RES  = 6'b100000
  } state_t;

  state_t state_r, state_nxt;

  // Next state and commands.
  always_comb begin
    logic finish;
    logic snap_go;
    finish = 1'b0;
    snap_go = 1'b0;
    state_nxt = state_r;
    cmd = '0;
    in_stall = 1'b1;
    case (state_r)
      S_CLR: begin
        cmd.clr_step = 1'b1;
        if (st.clr_done) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_nxt = S_DEC;
        end
      end
      S_DEC, S_WALK: begin
        if ((state_r == S_DEC) && (st.bad || st.empty)) begin
          finish = 1'b1;
        end else if (st.single) begin
          cmd.bit_op = 1'b1;
          finish = 1'b1;
        end else if (st.snap) begin
          snap_go = 1'b1;
        end else begin
          cmd.proc = 1'b1;
          if (st.last_word || st.hit) begin
            finish = 1'b1;
          end else begin
            cmd.step = 1'b1;
            state_nxt = S_WALK;
          end
        end
      end
      S_SNAP: begin
        snap_go = 1'b1;
      end
      S_RES: begin
        finish = 1'b1;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    // The single result of a request goes out as soon as the register frees.
    if (finish) begin
      if (st.out_free) begin
        cmd.load_res = 1'b1;
        state_nxt = S_IDLE;
      end else begin
        state_nxt = S_RES;
      end
    end

    // A snapshot sends one word per free output slot.
    if (snap_go) begin
      if (st.out_free) begin
        cmd.load_res = 1'b1;
        if (st.last_word) begin
          state_nxt = S_IDLE;
        end else begin
          cmd.step = 1'b1;
          state_nxt = S_SNAP;
        end
      end else begin
        state_nxt = S_SNAP;
      end
    end
  end

  // State register; reset starts the clearing pass.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLR;
    end else begin
      state_r <= state_nxt;
    end
  end

  // The output register is never overwritten while it holds an item.
  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_res |-> st.out_free)
    else $error("result loaded while output register busy");

  // A walk or snapshot never steps past the last word in use.
  a_step_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.step |-> !st.last_word)
    else $error("word step past the last word in use");

endmodule

// File: rtl/bse_dp.sv
// ============================================================================
// bse_dp: datapath of the bitmap set engine
// Holds the bitmap store, the request, the word counter, the walk
// accumulators and the output register.
// ============================================================================
module bse_dp #(
  parameter int CAPACITY_BITS = 1024
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic [bse_pkg::IDX_W-1:0]   bits_in_use,
  input  bse_pkg::req_t               in_data,
  output logic                        out_valid,
  input  logic                        out_stall,
  output bse_pkg::rsp_t               out_data,
  input  bse_pkg::cmd_t               cmd,
  output bse_pkg::stat_t              st
);

  localparam int STORE_WORDS = (CAPACITY_BITS + 15) / 16;
  localparam int AW = (STORE_WORDS > 1) ? $clog2(STORE_WORDS) : 1;
  localparam int N_LIMIT = (CAPACITY_BITS > 2047) ? 2047 : CAPACITY_BITS;
  localparam logic [bse_pkg::IDX_W-1:0] N_CAP = 11'(N_LIMIT);
  localparam logic [AW-1:0] LAST_ADDR = AW'(STORE_WORDS - 1);

  // Population count of one word.
  function automatic logic [4:0] pop16(input logic [15:0] w);
    logic [15:0] v;
    v = w - ((w >> 1) & 16'h5555);
    v = (v & 16'h3333) + ((v >> 2) & 16'h3333);
    v = (v + (v >> 4)) & 16'h0F0F;
    v = (v + (v >> 8)) & 16'h001F;
    return v[4:0];
  endfunction

  // Position of the lowest set bit of a nonzero word.
  function automatic logic [3:0] ffs16(input logic [15:0] w);
    logic [3:0] b;
    b = 4'd0;
    for (int i = 15; i >= 0; i--) begin
      if (w[i]) begin
        b = 4'(i);
      end
    end
    return b;
  endfunction

  bse_pkg::req_t                      req_r;
  logic [bse_pkg::WIDX_W-1:0]         cnt_r, cnt_nxt;
  logic                               any_r, any_nxt;
  logic [bse_pkg::IDX_W-1:0]          count_r, count_nxt;
  logic                               hit_r, hit_nxt;
  logic [bse_pkg::IDX_W-1:0]          found_r, found_nxt;
  logic                               bit_r, bit_nxt;
  logic [AW-1:0]                      clr_r;
  logic                               out_valid_r, out_valid_nxt;
  bse_pkg::rsp_t                      out_data_r, out_data_nxt;
  bse_pkg::rsp_t                      res;

  logic [bse_pkg::IDX_W-1:0]          n;
  logic [bse_pkg::WCNT_W-1:0]         wc;
  logic [bse_pkg::WORD_W-1:0]         tail;
  logic [bse_pkg::WORD_W-1:0]         rdata, w_m, bit_mask, wdata;
  logic [AW-1:0]                      raddr, waddr;
  logic                               we;
  logic                               bad;
  logic                               single, walk, fill, snap, scan;
  logic                               mod_set, mod_clr, reports_bit;
  logic                               in_first_word;
  logic [bse_pkg::WIDX_W-1:0]         in_start;

  // Effective bit count, words in use and tail mask.
  assign n = (bits_in_use > N_CAP) ? N_CAP : bits_in_use;
  assign wc = {1'b0, n[10:4]} + {7'd0, |n[3:0]};
  assign tail = (n[3:0] == 4'd0) ? 16'hFFFF : ~(16'hFFFF << n[3:0]);

  // Request class decode.
  assign single = req_r.req_type inside {[bse_pkg::REQ_SET:bse_pkg::REQ_TEST_CLEAR]};
  assign walk = req_r.req_type inside {bse_pkg::REQ_ANY, bse_pkg::REQ_COUNT,
                                       bse_pkg::REQ_SCAN};
  assign fill = req_r.req_type inside {bse_pkg::REQ_CLEAR_ALL, bse_pkg::REQ_FILL_ALL};
  assign snap = (req_r.req_type == bse_pkg::REQ_SNAPSHOT);
  assign scan = (req_r.req_type == bse_pkg::REQ_SCAN);
  assign mod_set = req_r.req_type inside {bse_pkg::REQ_SET, bse_pkg::REQ_TEST_SET};
  assign mod_clr = req_r.req_type inside {bse_pkg::REQ_CLEAR, bse_pkg::REQ_TEST_CLEAR};
  assign reports_bit = req_r.req_type inside {bse_pkg::REQ_TEST, bse_pkg::REQ_TEST_SET,
                                              bse_pkg::REQ_TEST_CLEAR};

  // Rejection checks.
  always_comb begin
    if (single) begin
      bad = (req_r.bit_index >= n);
    end else if (scan) begin
      bad = (req_r.bit_index > n);
    end else if (snap) begin
      bad = ({1'b0, req_r.dest_space} < wc) ||
            (wc > 8'(bse_pkg::MAX_SNAP_WORDS));
    end else begin
      bad = !(walk || fill);
    end
  end

  // First word of an incoming request.
  assign in_start = (in_data.req_type inside {[bse_pkg::REQ_SET:bse_pkg::REQ_TEST_CLEAR]} ||
                     in_data.req_type == bse_pkg::REQ_SCAN) ? in_data.bit_index[10:4]
                                                            : 7'd0;

  // Read address leads the counter so a word is ready the cycle it is used.
  always_comb begin
    if (cmd.accept) begin
      raddr = AW'(in_start);
    end else if (cmd.step) begin
      raddr = AW'(cnt_r + 7'd1);
    end else begin
      raddr = AW'(cnt_r);
    end
  end

  // Current word, masked to the bits in use and to the scan start.
  assign in_first_word = (cnt_r == req_r.bit_index[10:4]);
  always_comb begin
    w_m = rdata;
    if (st.last_word) begin
      w_m = w_m & tail;
    end
    if (scan && in_first_word) begin
      w_m = w_m & (16'hFFFF << req_r.bit_index[3:0]);
    end
  end

  assign st.bad = bad;
  assign st.single = single;
  assign st.snap = snap;
  assign st.empty = ({1'b0, cnt_r} >= wc);
  assign st.last_word = ({1'b0, cnt_r} == (wc - 8'd1));
  assign st.hit = scan && (w_m != 16'd0);
  assign st.out_free = !out_valid_r || !out_stall;
  assign st.clr_done = (clr_r == LAST_ADDR);

  // Store write port: clearing pass, single-bit update or fill.
  assign bit_mask = 16'd1 << req_r.bit_index[3:0];
  always_comb begin
    we = cmd.clr_step || (cmd.bit_op && !st.bad && (mod_set || mod_clr)) ||
         (cmd.proc && fill);
    waddr = cmd.clr_step ? clr_r : AW'(cnt_r);
    if (cmd.clr_step) begin
      wdata = 16'd0;
    end else if (fill) begin
      if (req_r.req_type == bse_pkg::REQ_FILL_ALL) begin
        wdata = st.last_word ? tail : 16'hFFFF;
      end else begin
        wdata = 16'd0;
      end
    end else if (mod_set) begin
      wdata = rdata | bit_mask;
    end else begin
      wdata = rdata & ~bit_mask;
    end
  end

  bse_ram #(
    .WIDTH(bse_pkg::WORD_W),
    .DEPTH(STORE_WORDS)
  ) u_store (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata(wdata),
    .raddr(raddr),
    .rdata(rdata)
  );

  // Word counter and walk accumulators.
  always_comb begin
    cnt_nxt = cnt_r;
    if (cmd.accept) begin
      cnt_nxt = in_start;
    end else if (cmd.step) begin
      cnt_nxt = cnt_r + 7'd1;
    end
    any_nxt = any_r;
    count_nxt = count_r;
    hit_nxt = hit_r;
    found_nxt = found_r;
    if (cmd.accept) begin
      any_nxt = 1'b0;
      count_nxt = 11'd0;
      hit_nxt = 1'b0;
    end else if (cmd.proc) begin
      any_nxt = any_r | (w_m != 16'd0);
      count_nxt = count_r + 11'(pop16(w_m));
      if (st.hit) begin
        hit_nxt = 1'b1;
        found_nxt = {cnt_r, ffs16(w_m)};
      end
    end
    bit_nxt = cmd.bit_op ? rdata[req_r.bit_index[3:0]] : bit_r;
  end

  // Result item built from the request and the accumulators.
  always_comb begin
    res = '0;
    res.last = 1'b1;
    if (!st.bad) begin
      res.ok = 1'b1;
      if (reports_bit) begin
        res.bit_value = bit_nxt;
      end
      if (req_r.req_type == bse_pkg::REQ_ANY) begin
        res.any_set = any_nxt;
      end
      if (req_r.req_type == bse_pkg::REQ_COUNT) begin
        res.set_count = count_nxt;
      end
      if (scan) begin
        res.found_index = hit_nxt ? found_nxt : n;
      end
      if (snap && !st.empty) begin
        res.word_data = w_m;
        res.last = st.last_word;
      end
    end
  end

  // Output register.
  assign out_valid_nxt = cmd.load_res ? 1'b1 : (out_stall ? out_valid_r : 1'b0);
  assign out_data_nxt = cmd.load_res ? res : out_data_r;
  assign out_valid = out_valid_r;
  assign out_data = out_data_r;

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      clr_r <= '0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (cmd.clr_step) begin
        clr_r <= clr_r + AW'(1);
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      req_r <= in_data;
    end
    cnt_r <= cnt_nxt;
    any_r <= any_nxt;
    count_r <= count_nxt;
    hit_r <= hit_nxt;
    found_r <= found_nxt;
    bit_r <= bit_nxt;
    out_data_r <= out_data_nxt;
  end

  // A walk only touches words in use.
  a_walk_range: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.proc |-> ({1'b0, cnt_r} < wc))
    else $error("walk reached a word beyond the bits in use");

  // A single-bit access only happens for an index in range.
  a_bit_range: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.bit_op && single) |-> (req_r.bit_index < n))
    else $error("single-bit access with index out of range");

endmodule
